### hdl/wlsd_pkg.sv
// ----------------------------------------------------------------------------
// wlsd_pkg
// Shared types and constants for the word list stream decoder.
// ----------------------------------------------------------------------------
package wlsd_pkg;

    // widths fixed by the stream format
    localparam int unsigned ByteW    = 8;
    localparam int unsigned LenW     = 16;
    localparam int unsigned ValW     = 25;
    localparam int unsigned LetterW  = 5;
    localparam int unsigned NumLet   = 5;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned LowW     = 7;

    // step byte coding: position = low / StepDiv, amount = low % StepDiv + 1
    localparam logic [LowW-1:0]    StepDiv    = 7'd25;
    localparam logic [LetterW:0]   AlphaSize  = 6'd26;
    localparam logic [LetterW:0]   AlphaLast  = 6'd25;
    localparam logic [LenW-1:0]    CountMax   = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SINGLE_LEN = 1'b0,
        CFG_PATH_LEN   = 1'b1
    } cfg_idx_t;

    // decode phase, also the code for the stream that supplies the next byte
    typedef enum logic [1:0] {
        PH_SINGLE = 2'd0,
        PH_PATH   = 2'd1,
        PH_STEP   = 2'd2,
        PH_END    = 2'd3
    } phase_t;

    typedef logic [LetterW-1:0] letter_t;

    typedef struct packed {
        phase_t                 phase;
        logic [LenW-1:0]        count;
        logic [ValW-1:0]        acc;
        logic [ValW-1:0]        running;
        letter_t [NumLet-1:0]   letters;
    } dec_state_t;

    typedef struct packed {
        logic                   word_valid;
        letter_t [NumLet-1:0]   letters;
        phase_t                 next_source;
    } dec_result_t;

endpackage

### hdl/wlsd_decode.sv
// ----------------------------------------------------------------------------
// wlsd_decode
// Combinational decode of one byte: next decoder state and the result item.
// ----------------------------------------------------------------------------
module wlsd_decode
    import wlsd_pkg::*;
(
    input  logic [ByteW-1:0] data_byte,
    input  dec_state_t       st,
    input  logic [LenW-1:0]  single_len,
    input  logic [LenW-1:0]  path_len,
    output dec_state_t       st_next,
    output dec_result_t      result
);

    logic [ValW-1:0]      acc_shift;
    logic [ValW-1:0]      sum;
    logic [LenW-1:0]      cnt_inc;
    letter_t [NumLet-1:0] sum_letters;
    letter_t [NumLet-1:0] step_letters;
    logic [LowW-1:0]      low;
    logic [2:0]           pos;
    logic [LowW-1:0]      rem;
    logic [LetterW-1:0]   amt;
    logic [LetterW:0]     rot;
    logic                 stop_bit;

    assign stop_bit = data_byte[ByteW-1];
    assign low      = data_byte[LowW-1:0];

    // varint accumulate, saturating byte count, running value update
    assign acc_shift = {st.acc[ValW-LowW-1:0], low};
    assign cnt_inc   = (st.count == CountMax) ? st.count : st.count + 1'b1;
    assign sum       = st.running + acc_shift + {{(ValW-1){1'b0}}, 1'b1};

    // unpack the new running value, first letter in the top bits
    always_comb begin
        for (int k = 0; k < NumLet; k++) begin
            sum_letters[k] = sum[LetterW*(NumLet-1-k) +: LetterW];
        end
    end

    // step byte: constant divide by compare chain
    always_comb begin
        if (low >= 7'(4 * StepDiv + StepDiv)) begin
            pos = 3'd5;
            rem = low - 7'(5 * StepDiv);
        end else if (low >= 7'(4 * StepDiv)) begin
            pos = 3'd4;
            rem = low - 7'(4 * StepDiv);
        end else if (low >= 7'(3 * StepDiv)) begin
            pos = 3'd3;
            rem = low - 7'(3 * StepDiv);
        end else if (low >= 7'(2 * StepDiv)) begin
            pos = 3'd2;
            rem = low - 7'(2 * StepDiv);
        end else if (low >= StepDiv) begin
            pos = 3'd1;
            rem = low - StepDiv;
        end else begin
            pos = 3'd0;
            rem = low;
        end
    end

    assign amt = rem[LetterW-1:0] + 1'b1;

    // rotate the selected letter, positions past the last letter do nothing
    always_comb begin
        step_letters = st.letters;
        rot          = '0;
        for (int k = 0; k < NumLet; k++) begin
            if (pos == 3'(k)) begin
                rot = {1'b0, st.letters[k]} + {1'b0, amt};
                if (rot > AlphaLast) begin
                    rot = rot - AlphaSize;
                end
                step_letters[k] = rot[LetterW-1:0];
            end
        end
    end

    // next state
    always_comb begin
        st_next = st;
        case (st.phase)
            PH_SINGLE, PH_PATH: begin
                st_next.count = cnt_inc;
                st_next.acc   = acc_shift;
                if (stop_bit) begin
                    st_next.acc     = '0;
                    st_next.running = sum;
                    st_next.letters = sum_letters;
                    if (st.phase == PH_PATH) begin
                        st_next.phase = PH_STEP;
                    end else if (cnt_inc >= single_len) begin
                        st_next.phase   = PH_PATH;
                        st_next.count   = '0;
                        st_next.running = '0;
                    end
                end
            end
            PH_STEP: begin
                st_next.letters = step_letters;
                if (stop_bit) begin
                    st_next.phase = (st.count >= path_len) ? PH_END : PH_PATH;
                end
            end
            default: begin
                st_next = st;
            end
        endcase
    end

    // result item
    always_comb begin
        case (st.phase)
            PH_SINGLE, PH_PATH: result.word_valid = stop_bit;
            PH_STEP:            result.word_valid = 1'b1;
            default:            result.word_valid = 1'b0;
        endcase
        result.letters     = result.word_valid ? st_next.letters : '0;
        result.next_source = st_next.phase;
    end

endmodule

### hdl/wlsd_out_reg.sv
// ----------------------------------------------------------------------------
// wlsd_out_reg
// Result register with valid flag, refilled in the cycle it is taken.
// ----------------------------------------------------------------------------
module wlsd_out_reg
    import wlsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  dec_result_t result_in,
    input  logic        m_ready,
    output logic        m_valid,
    output dec_result_t result_out
);

    logic        valid_reg;
    logic        valid_next;
    dec_result_t data_reg;

    // valid flag: set on load, cleared when the transfer completes
    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

endmodule

### hdl/word_list_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// word_list_stream_decoder_top
// Path: an accepted byte waits in the input register, is decoded combinationally
// and its result is loaded into the result register once that register has room.
// Throughput: one byte per cycle while results are taken; the input and result
// registers let a new byte in while a finished result still waits to be taken.
// Reset: synchronous active-low aresetn clears phase, count, accumulator,
// running value, letters, both length registers and all valid flags.
// ----------------------------------------------------------------------------
module word_list_stream_decoder_top
    import wlsd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [LenW-1:0]    cfg_data,
    // byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ByteW-1:0]   s_data_byte,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_word_valid,
    output logic [LetterW-1:0] m_letter_first,
    output logic [LetterW-1:0] m_letter_second,
    output logic [LetterW-1:0] m_letter_third,
    output logic [LetterW-1:0] m_letter_fourth,
    output logic [LetterW-1:0] m_letter_fifth,
    output logic [1:0]         m_next_source
);

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             advance;
    logic [LenW-1:0]  single_len_reg;
    logic [LenW-1:0]  path_len_reg;
    dec_state_t       st_reg;
    dec_state_t       st_next;
    dec_result_t      res_next;
    dec_result_t      res_out;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            single_len_reg <= '0;
            path_len_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SINGLE_LEN: single_len_reg <= cfg_data;
                CFG_PATH_LEN:   path_len_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // input register: decode moves on when the result register has room
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: PH_SINGLE, count: '0, acc: '0, running: '0, letters: '0};
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    wlsd_decode u_decode (
        .data_byte  (in_byte_reg),
        .st         (st_reg),
        .single_len (single_len_reg),
        .path_len   (path_len_reg),
        .st_next    (st_next),
        .result     (res_next)
    );

    wlsd_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result_in  (res_next),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .result_out (res_out)
    );

    // result fields
    assign m_word_valid    = res_out.word_valid;
    assign m_letter_first  = res_out.letters[0];
    assign m_letter_second = res_out.letters[1];
    assign m_letter_third  = res_out.letters[2];
    assign m_letter_fourth = res_out.letters[3];
    assign m_letter_fifth  = res_out.letters[4];
    assign m_next_source   = res_out.next_source;

    // a result without a word carries blank letters
    a_blank_letters: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_word_valid) |-> (res_out.letters == '0))
        else $error("letters set on a result without a word");

    // the finished phase is never left
    a_end_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == PH_END) |=> (st_reg.phase == PH_END))
        else $error("decoder left the finished phase");

    // input is held off only when both stages are full and the output stalls
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a full pipeline");

    // every decoded byte lands in the result register
    a_decode_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("decoded byte produced no result");

endmodule

### bench/tb_word_list_stream_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_word_list_stream_decoder_top
// Self-checking bench for the word list stream decoder. A byte driver and a
// result monitor run as clocked processes around the block, and a cycle-free
// decoder model predicts each result as its byte is taken. Stimulus covers
// the single stream, the switch to path words, rotation steps, long varints
// and the finished state, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_word_list_stream_decoder_top;
    import wlsd_pkg::*;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS    = 10;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [LenW-1:0]    cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ByteW-1:0]   s_data_byte = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_word_valid;
    logic [LetterW-1:0] m_letter_first;
    logic [LetterW-1:0] m_letter_second;
    logic [LetterW-1:0] m_letter_third;
    logic [LetterW-1:0] m_letter_fourth;
    logic [LetterW-1:0] m_letter_fifth;
    logic [1:0]         m_next_source;

    // byte stream waiting to be sent and words waiting to come out
    logic [ByteW-1:0] byte_q[$];
    dec_result_t      word_expect_q[$];

    // decoder model state and length registers
    phase_t           dec_phase = PH_SINGLE;
    logic [LenW-1:0]  byte_count = '0;
    logic [ValW-1:0]  varint_acc = '0;
    logic [ValW-1:0]  running_word = '0;
    letter_t          cur_letters [NumLet];
    logic [LenW-1:0]  single_len = '0;
    logic [LenW-1:0]  path_len = '0;

    // handshake bookkeeping and idling control
    logic             byte_taken = 1'b0;
    logic             word_taken = 1'b0;
    logic             tx_idle_en = 1'b0;
    logic             rx_idle_en = 1'b0;
    logic             rx_hold = 1'b0;
    int unsigned      tx_gap_left = 0;
    int unsigned      rx_wait_left = 0;
    event             rx_hold_go;

    int unsigned      mismatch_count = 0;
    int unsigned      bytes_in = 0;
    int unsigned      results_out = 0;
    int unsigned      words_out = 0;

    word_list_stream_decoder_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_word_valid    (m_word_valid),
        .m_letter_first  (m_letter_first),
        .m_letter_second (m_letter_second),
        .m_letter_third  (m_letter_third),
        .m_letter_fourth (m_letter_fourth),
        .m_letter_fifth  (m_letter_fifth),
        .m_next_source   (m_next_source)
    );

    // clock
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // wait cycles for one item on either side
    function automatic int unsigned draw_wait(input logic enable);
        if (!enable || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // advance the decoder model by one byte and return the result it gives
    function automatic dec_result_t decode_byte(input logic [ByteW-1:0] b);
        dec_result_t      res;
        logic             done;
        logic [LowW-1:0]  low;
        logic [LowW-1:0]  pos;
        logic [LetterW:0] sum;
        res  = '0;
        done = 1'b0;
        low  = b[LowW-1:0];
        case (dec_phase)
            PH_SINGLE, PH_PATH: begin
                if (byte_count != CountMax)
                    byte_count++;
                varint_acc = {varint_acc[ValW-LowW-1:0], low};
                if (b[ByteW-1]) begin
                    running_word = running_word + varint_acc + 1'b1;
                    varint_acc   = '0;
                    for (int k = 0; k < NumLet; k++)
                        cur_letters[k] = running_word[LetterW*(NumLet-1-k) +: LetterW];
                    done = 1'b1;
                    if (dec_phase == PH_PATH) begin
                        dec_phase = PH_STEP;
                    end else if (byte_count >= single_len) begin
                        dec_phase    = PH_PATH;
                        byte_count   = '0;
                        running_word = '0;
                    end
                end
            end
            PH_STEP: begin
                pos = low / StepDiv;
                if (pos < NumLet) begin
                    sum = {1'b0, cur_letters[pos]} + (low % StepDiv) + 1'b1;
                    if (sum > AlphaLast)
                        sum = sum - AlphaSize;
                    cur_letters[pos] = sum[LetterW-1:0];
                end
                done = 1'b1;
                if (b[ByteW-1])
                    dec_phase = (byte_count >= path_len) ? PH_END : PH_PATH;
            end
            default: ;
        endcase
        res.word_valid = done;
        if (done)
            for (int k = 0; k < NumLet; k++)
                res.letters[k] = cur_letters[k];
        res.next_source = dec_phase;
        return res;
    endfunction

    // byte driver: holds each byte until taken, then waits its drawn gap
    always @(negedge aclk) begin : drive_bytes
        logic             nxt_valid;
        logic [ByteW-1:0] nxt_byte;
        nxt_valid = s_valid;
        nxt_byte  = s_data_byte;
        if (!aresetn) begin
            nxt_valid   = 1'b0;
            tx_gap_left = 0;
        end else begin
            if (s_valid && byte_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (tx_gap_left != 0) begin
                    tx_gap_left--;
                end else if (byte_q.size() != 0) begin
                    nxt_byte    = byte_q.pop_front();
                    nxt_valid   = 1'b1;
                    tx_gap_left = draw_wait(tx_idle_en);
                end
            end
        end
        s_valid     <= nxt_valid;
        s_data_byte <= nxt_byte;
    end

    // result ready: a drawn wait after every transfer, plus the long hold-off
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            rx_wait_left = 0;
            m_ready <= 1'b0;
        end else begin
            if (word_taken)
                rx_wait_left = draw_wait(rx_idle_en);
            if (rx_wait_left != 0) begin
                rx_wait_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_hold;
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering
    always begin : hold_results
        @(rx_hold_go);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    // monitor: check each result transfer, then predict each byte transfer
    always @(posedge aclk) begin : check_words
        dec_result_t got;
        dec_result_t want;
        if (!aresetn) begin
            byte_taken   <= 1'b0;
            word_taken   <= 1'b0;
            dec_phase    = PH_SINGLE;
            byte_count   = '0;
            varint_acc   = '0;
            running_word = '0;
            single_len   = '0;
            path_len     = '0;
            for (int k = 0; k < NumLet; k++)
                cur_letters[k] = '0;
        end else begin
            byte_taken <= s_valid && s_ready;
            word_taken <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                got.word_valid  = m_word_valid;
                got.letters[0]  = m_letter_first;
                got.letters[1]  = m_letter_second;
                got.letters[2]  = m_letter_third;
                got.letters[3]  = m_letter_fourth;
                got.letters[4]  = m_letter_fifth;
                got.next_source = phase_t'(m_next_source);
                results_out++;
                if (word_expect_q.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result %0d with no byte pending", results_out);
                    mismatch_count++;
                end else begin
                    want = word_expect_q.pop_front();
                    if (want.word_valid)
                        words_out++;
                    if (got.word_valid !== want.word_valid || got.letters !== want.letters
                            || got.next_source !== want.next_source) begin
                        if (mismatch_count < MAX_REPORTS)
                            $display({"result %0d: expected valid %0b letters %0d %0d %0d %0d",
                                      " %0d next %0d, got valid %0b letters %0d %0d %0d %0d",
                                      " %0d next %0d"}, results_out,
                                     want.word_valid, want.letters[0], want.letters[1],
                                     want.letters[2], want.letters[3], want.letters[4],
                                     want.next_source, got.word_valid, got.letters[0],
                                     got.letters[1], got.letters[2], got.letters[3],
                                     got.letters[4], got.next_source);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                bytes_in++;
                word_expect_q.push_back(decode_byte(s_data_byte));
            end
        end
    end

    // one length register write; the model takes the value at the transfer
    task automatic write_len(input cfg_idx_t idx, input logic [LenW-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_SINGLE_LEN)
            single_len = value;
        else
            path_len = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // sender pause until every byte is through and every result is back
    task automatic wait_drained;
        do begin
            @(posedge aclk);
            #1;
        end while (byte_q.size() != 0 || s_valid || word_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // varint of n bytes: continuation bytes first, terminator last
    task automatic push_varint(input int unsigned n);
        for (int unsigned i = 1; i < n; i++)
            byte_q.push_back({1'b0, 7'($urandom)});
        byte_q.push_back({1'b1, 7'($urandom)});
    endtask

    // run of n step bytes, the last one returning to the path stream
    task automatic push_steps(input int unsigned n);
        for (int unsigned i = 1; i < n; i++)
            byte_q.push_back({1'b0, 7'($urandom)});
        byte_q.push_back({1'b1, 7'($urandom)});
    endtask

    // mostly short varints, now and then a long one that overflows 25 bits
    function automatic int unsigned pick_varint_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 1;
        if (r < 70) return 2;
        if (r < 90) return 3;
        return $urandom_range(4, 6);
    endfunction

    // main sequence
    initial begin : run_stimulus
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_len(CFG_SINGLE_LEN, 16'hFFFF);
        write_len(CFG_PATH_LEN, 16'hFFFF);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // single stream: zero and full continuation bytes, smallest delta,
        // then a long varint that overflows the accumulator and wraps the word
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h7F);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h80);
        repeat (4) byte_q.push_back(8'h7F);
        byte_q.push_back(8'hFF);
        wait_drained();

        // back-to-back bytes against a long result hold-off
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        -> rx_hold_go;
        repeat (60) push_varint(pick_varint_len());
        while (byte_q.size() != 0) @(posedge aclk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (220) push_varint(pick_varint_len());
        wait_drained();

        // single stream ends on exactly the programmed length
        write_len(CFG_SINGLE_LEN, byte_count + 16'd2);
        byte_q.push_back(8'h05);
        byte_q.push_back(8'h81);
        // base word with every letter at 31, wrapping and ignored steps
        repeat (3) byte_q.push_back(8'h7F);
        byte_q.push_back(8'hFE);
        byte_q.push_back(8'h18);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h7D);
        byte_q.push_back(8'h64);
        byte_q.push_back(8'hE4);

        // path words with step runs; some single-step runs and long varints
        repeat (95) begin
            push_varint(pick_varint_len());
            push_steps(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 8));
        end
        wait_drained();

        // new lengths mid-stream: single length no longer consulted
        write_len(CFG_SINGLE_LEN, 16'h0000);
        write_len(CFG_PATH_LEN, 16'($urandom_range(20000, 60000)));
        tx_idle_en = 1'b0;
        repeat (40) begin
            push_varint(pick_varint_len());
            push_steps($urandom_range(1, 8));
        end
        while (byte_q.size() != 0) @(posedge aclk);
        tx_idle_en = 1'b1;
        repeat (55) begin
            push_varint(pick_varint_len());
            push_steps(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 8));
        end
        wait_drained();

        // very long path varint, then a stop step with the path length reached
        write_len(CFG_PATH_LEN, 16'h0000);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        push_varint(40);
        push_steps(1);
        repeat (6) byte_q.push_back(8'($urandom));
        wait_drained();

        // finished decoder ignores bytes whatever the lengths
        write_len(CFG_PATH_LEN, 16'hFFFF);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (4) byte_q.push_back(8'($urandom));
        wait_drained();

        $display("covered %0d bytes and %0d results, %0d of them completed words",
                 bytes_in, results_out, words_out);
        $display("decoder ended in phase %0d, %0d result mismatches",
                 dec_phase, mismatch_count);
        if (mismatch_count == 0 && word_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin : run_limit
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
